[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the grid lookup block.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RGNI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgni assertion failed");
`define RGNI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgni assertion failed");
`else
`define RGNI_ASSERT_IMP(lbl, ante, cons)
`define RGNI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/rgni_pkg.sv]
// Types and constants of the regular grid nearest index block.
// No dependencies; used by rgni_axis and regular_grid_nearest_index.
package rgni_pkg;

	localparam int unsigned IDX_W   = 10;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned CNT_W   = 11;

	typedef enum logic [1:0] {
		OP_LOAD_LAT = 2'd0,
		OP_LOAD_LON = 2'd1,
		OP_QUERY    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN
	} state_t;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [CNT_W-1:0] ROWS_RESET = 11'd1024;
	localparam logic [CNT_W-1:0] COLS_RESET = 11'd1024;

	typedef struct packed {
		logic clearing;
		logic done;
		logic have;
	} axis_status_t;

endpackage

[rtl/core/rgni_axis.sv]
// One axis table with its valid marks and a sequential nearest-entry scan unit.
// Depends on rgni_pkg.
module rgni_axis import rgni_pkg::*; #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic signed [COORD_W-1:0] wr_value,
	input  logic                      wr_ok,
	input  logic                      scan_start,
	input  logic [CNT_W-1:0]          scan_len,
	input  logic signed [COORD_W-1:0] target,
	output axis_status_t              status,
	output logic [AW-1:0]             best_index
);

	logic [COORD_W:0] mem [DEPTH];

	logic                      clr_q;
	logic [AW-1:0]             clr_addr_q;
	logic                      run_q;
	logic [CW-1:0]             addr_q;
	logic [CW-1:0]             len_q;
	logic signed [COORD_W-1:0] target_q;
	logic                      v_s1;
	logic [AW-1:0]             idx_s1;
	logic [COORD_W:0]          rd_data_s1;
	logic                      v_s2;
	logic                      ok_s2;
	logic [AW-1:0]             idx_s2;
	logic [COORD_W:0]          mag_s2;
	logic                      have_q;
	logic [COORD_W:0]          best_q;
	logic [AW-1:0]             best_idx_q;

	logic             wr_hit;
	logic [AW-1:0]    wr_addr;
	logic [CW-1:0]    len_eff;
	logic             issue;
	logic             fin;
	logic [COORD_W:0] diff;
	logic [COORD_W:0] mag;
	logic             better;

	assign wr_hit  = wr_en && (32'(wr_index) < DEPTH);
	assign wr_addr = AW'(wr_index);
	assign len_eff = (32'(scan_len) > DEPTH) ? CW'(DEPTH) : CW'(scan_len);
	assign issue   = run_q && (addr_q != len_q);
	assign fin     = run_q && !issue && !v_s1 && !v_s2;

	assign diff   = {rd_data_s1[COORD_W-1], rd_data_s1[COORD_W-1:0]}
		- {target_q[COORD_W-1], target_q};
	assign mag    = diff[COORD_W] ? (~diff + 1'b1) : diff;
	assign better = ok_s2 && (!have_q || (mag_s2 < best_q));

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_hit) begin
			mem[wr_addr] <= {wr_ok, wr_value};
		end
		if (issue) begin
			rd_data_s1 <= mem[addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			addr_q <= '0;
			len_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			have_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (scan_start) begin
				run_q  <= 1'b1;
				addr_q <= '0;
				len_q  <= len_eff;
				have_q <= 1'b0;
			end else begin
				if (issue) begin
					addr_q <= addr_q + 1'b1;
				end
				if (v_s2 && better) begin
					have_q <= 1'b1;
				end
				if (fin) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			target_q <= target;
		end
		if (issue) begin
			idx_s1 <= addr_q[AW-1:0];
		end
		if (v_s1) begin
			idx_s2 <= idx_s1;
			ok_s2  <= rd_data_s1[COORD_W];
			mag_s2 <= mag;
		end
		if (v_s2 && better) begin
			best_q     <= mag_s2;
			best_idx_q <= idx_s2;
		end
	end

	assign status.clearing = clr_q;
	assign status.done     = fin;
	assign status.have     = have_q;
	assign best_index      = best_idx_q;

endmodule

[rtl/core/regular_grid_nearest_index.sv]
// Top level of the regular grid nearest index block: APB registers and sequencer.
// Depends on rgni_pkg, rgni_axis and assert_macros.svh.
//
// Load items (latitude or longitude entry) are written into their table and busy stays
// low. A query with query_valid set scans both axis tables side by side, one
// entry per cycle from a registered memory read through a distance and a compare
// stage; result_strobe rises once both scans are through, each over its scan length
// (the row or column count register, capped at its table depth), and busy stays
// high until then. A query with query_valid low answers in the next cycle. Results
// show for one cycle on result_strobe and cannot be held off. After reset the block
// clears all valid marks, one entry per cycle, and holds busy high until both tables
// are clear; register writes are taken during that pass.
`include "assert_macros.svh"

module regular_grid_nearest_index import rgni_pkg::*; #(
	parameter int unsigned MAX_ROWS = 1024,
	parameter int unsigned MAX_COLS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic [IDX_W-1:0]          entry_index,
	input  logic signed [COORD_W-1:0] entry_value,
	input  logic                      entry_valid,
	input  logic signed [COORD_W-1:0] query_lat,
	input  logic signed [COORD_W-1:0] query_lon,
	input  logic                      query_valid,
	output logic                      result_strobe,
	output logic [IDX_W-1:0]          row_index,
	output logic [IDX_W-1:0]          col_index,
	output logic                      found
);

	localparam int unsigned RAW = $clog2(MAX_ROWS);
	localparam int unsigned CAW = $clog2(MAX_COLS);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] rows_q;
	logic [CNT_W-1:0] cols_q;
	logic             row_done_q;
	logic             col_done_q;
	logic             result_strobe_q;
	logic [IDX_W-1:0] row_index_q;
	logic [IDX_W-1:0] col_index_q;
	logic             found_q;

	axis_status_t   row_st;
	axis_status_t   col_st;
	logic [RAW-1:0] row_best;
	logic [CAW-1:0] col_best;

	logic cfg_wr;
	logic accept;
	logic is_query;
	logic row_wr;
	logic col_wr;
	logic scan_go;
	logic emit_invalid;
	logic row_fin;
	logic col_fin;
	logic emit_scan;
	logic hit;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = 32'(rows_q);
			REG_COLS: prdata = 32'(cols_q);
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[CNT_W-1:0];
				REG_COLS: cols_q <= pwdata[CNT_W-1:0];
				default:  ;
			endcase
		end
	end

	assign accept       = start && !busy;
	assign is_query     = opcode == OP_QUERY;
	assign row_wr       = accept && (opcode == OP_LOAD_LAT);
	assign col_wr       = accept && (opcode == OP_LOAD_LON);
	assign scan_go      = accept && is_query && query_valid;
	assign emit_invalid = accept && is_query && !query_valid;
	assign row_fin      = row_done_q || row_st.done;
	assign col_fin      = col_done_q || col_st.done;
	assign emit_scan    = (state_q == ST_SCAN) && row_fin && col_fin;
	assign hit          = row_st.have && col_st.have;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (!row_st.clearing && !col_st.clearing) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (scan_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (emit_scan) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_INIT;
			row_done_q      <= 1'b0;
			col_done_q      <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			state_q         <= state_d;
			result_strobe_q <= emit_scan || emit_invalid;
			if (emit_scan || scan_go) begin
				row_done_q <= 1'b0;
				col_done_q <= 1'b0;
			end else begin
				if (row_st.done) begin
					row_done_q <= 1'b1;
				end
				if (col_st.done) begin
					col_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_scan) begin
			found_q     <= hit;
			row_index_q <= hit ? IDX_W'(row_best) : '0;
			col_index_q <= hit ? IDX_W'(col_best) : '0;
		end else if (emit_invalid) begin
			found_q     <= 1'b0;
			row_index_q <= '0;
			col_index_q <= '0;
		end
	end

	assign result_strobe = result_strobe_q;
	assign row_index     = row_index_q;
	assign col_index     = col_index_q;
	assign found         = found_q;

	rgni_axis #(
		.DEPTH(MAX_ROWS)
	) u_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (row_wr),
		.wr_index  (entry_index),
		.wr_value  (entry_value),
		.wr_ok     (entry_valid),
		.scan_start(scan_go),
		.scan_len  (rows_q),
		.target    (query_lat),
		.status    (row_st),
		.best_index(row_best)
	);

	rgni_axis #(
		.DEPTH(MAX_COLS)
	) u_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (col_wr),
		.wr_index  (entry_index),
		.wr_value  (entry_value),
		.wr_ok     (entry_valid),
		.scan_start(scan_go),
		.scan_len  (cols_q),
		.target    (query_lon),
		.status    (col_st),
		.best_index(col_best)
	);

	`RGNI_ASSERT_IMP(a_miss_zero, result_strobe && !found, row_index == '0 && col_index == '0)
	`RGNI_ASSERT_IMP(a_clear_busy, row_st.clearing || col_st.clearing, busy)
	`RGNI_ASSERT_NXT(a_query_scan, scan_go, state_q == ST_SCAN && !result_strobe)

endmodule

[test/tb_regular_grid_nearest_index.sv]
// Testbench for regular_grid_nearest_index: axis table loads, point queries, APB settings.
// Depends on rgni_pkg; checks each result against an in-bench nearest-entry predictor or a typed value.
module tb_regular_grid_nearest_index import rgni_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TAB_DEPTH  = 1024;
	localparam int          NUM_PHASES = 8;
	localparam int          CALM_PHASE = 1;
	localparam int          SETTLE     = 8;
	localparam int          DRAIN      = 1100;
	localparam longint      LIMIT      = 600_000;
	localparam logic [1:0]  OP_UNUSED  = 2'd3;
	localparam logic [2:0]  ADDR_ROWS  = {REG_ROWS, 2'b00};
	localparam logic [2:0]  ADDR_COLS  = {REG_COLS, 2'b00};

	typedef struct {
		logic [1:0]                op;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] val;
		logic                      ev;
		logic signed [COORD_W-1:0] qlat;
		logic signed [COORD_W-1:0] qlon;
		logic                      qv;
		bit                        typed;
		logic [IDX_W-1:0]          er;
		logic [IDX_W-1:0]          ec;
		logic                      ef;
	} grid_cmd_t;

	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             fnd;
	} lookup_res_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      psel        = 1'b0;
	logic                      penable     = 1'b0;
	logic                      pwrite      = 1'b0;
	logic [2:0]                paddr       = '0;
	logic [31:0]               pwdata      = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      start       = 1'b0;
	logic                      busy;
	logic [1:0]                opcode      = '0;
	logic [IDX_W-1:0]          entry_index = '0;
	logic signed [COORD_W-1:0] entry_value = '0;
	logic                      entry_valid = 1'b0;
	logic signed [COORD_W-1:0] query_lat   = '0;
	logic signed [COORD_W-1:0] query_lon   = '0;
	logic                      query_valid = 1'b0;
	logic                      result_strobe;
	logic [IDX_W-1:0]          row_index;
	logic [IDX_W-1:0]          col_index;
	logic                      found;

	logic signed [COORD_W-1:0] lat_val [TAB_DEPTH];
	bit                        lat_ok  [TAB_DEPTH];
	logic signed [COORD_W-1:0] lon_val [TAB_DEPTH];
	bit                        lon_ok  [TAB_DEPTH];
	logic [CNT_W-1:0]          rows_cfg = ROWS_RESET;
	logic [CNT_W-1:0]          cols_cfg = COLS_RESET;

	lookup_res_t lookup_q[$];
	int          errors    = 0;
	int          n_loads   = 0;
	int          n_queries = 0;
	int          n_hits    = 0;
	longint      cycles    = 0;

	int plan_rows  [NUM_PHASES] = '{1, 16, 0, 40, 2047, 8, 1024, 5};
	int plan_cols  [NUM_PHASES] = '{1, 16, 8, 3, 1025, 0, 1, 64};
	int plan_items [NUM_PHASES] = '{60, 130, 30, 130, 25, 35, 20, 150};

	regular_grid_nearest_index i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.entry_valid  (entry_valid),
		.query_lat    (query_lat),
		.query_lon    (query_lon),
		.query_valid  (query_valid),
		.result_strobe(result_strobe),
		.row_index    (row_index),
		.col_index    (col_index),
		.found        (found)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void nearest_entry(input bit on_lat, input logic [CNT_W-1:0] cfg,
			input logic signed [COORD_W-1:0] target, output bit have,
			output logic [IDX_W-1:0] idx);
		int     n;
		longint d;
		longint best;
		have = 1'b0;
		idx  = '0;
		best = 0;
		n    = (cfg > TAB_DEPTH) ? TAB_DEPTH : int'(cfg);
		for (int i = 0; i < n; i++) begin
			if (on_lat ? !lat_ok[i] : !lon_ok[i])
				continue;
			d = longint'(on_lat ? lat_val[i] : lon_val[i]) - longint'(target);
			if (d < 0)
				d = -d;
			if (!have || d < best) begin
				have = 1'b1;
				best = d;
				idx  = IDX_W'(i);
			end
		end
	endfunction

	function automatic lookup_res_t predict_lookup(input logic signed [COORD_W-1:0] lat,
			input logic signed [COORD_W-1:0] lon, input logic qv);
		lookup_res_t      r;
		bit               hr;
		bit               hc;
		logic [IDX_W-1:0] ir;
		logic [IDX_W-1:0] ic;
		r = '{row: '0, col: '0, fnd: 1'b0};
		if (qv) begin
			nearest_entry(1'b1, rows_cfg, lat, hr, ir);
			nearest_entry(1'b0, cols_cfg, lon, hc, ic);
			if (hr && hc)
				r = '{row: ir, col: ic, fnd: 1'b1};
		end
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
			default: return int'($urandom_range(16)) - 8;
		endcase
	endfunction

	function automatic grid_cmd_t load_cmd(input logic [1:0] op, input logic [IDX_W-1:0] idx,
			input logic signed [COORD_W-1:0] val, input logic ev);
		grid_cmd_t c;
		c = '{op: op, idx: idx, val: val, ev: ev, qlat: $urandom, qlon: $urandom,
			qv: 1'($urandom_range(1)), typed: 1'b0, er: '0, ec: '0, ef: 1'b0};
		return c;
	endfunction

	function automatic grid_cmd_t query_cmd(input logic signed [COORD_W-1:0] lat,
			input logic signed [COORD_W-1:0] lon, input logic qv, input bit typed,
			input logic [IDX_W-1:0] er, input logic [IDX_W-1:0] ec, input logic ef);
		grid_cmd_t c;
		c = '{op: OP_QUERY, idx: IDX_W'($urandom), val: $urandom,
			ev: 1'($urandom_range(1)), qlat: lat, qlon: lon, qv: qv, typed: typed,
			er: er, ec: ec, ef: ef};
		return c;
	endfunction

	function automatic grid_cmd_t random_cmd();
		grid_cmd_t   c;
		int unsigned sel;
		int unsigned span;
		int unsigned hi;
		sel = $urandom_range(99);
		if (sel < 72) begin
			c    = load_cmd((sel < 36) ? OP_LOAD_LAT : OP_LOAD_LON, '0, rand_coord(),
				$urandom_range(99) < 85);
			span = (sel < 36) ? 32'(rows_cfg) : 32'(cols_cfg);
			if (span > TAB_DEPTH)
				span = TAB_DEPTH;
			if (span == 0)
				span = 8;
			hi = (span + 1 > TAB_DEPTH - 1) ? TAB_DEPTH - 1 : span + 1;
			c.idx = IDX_W'(($urandom_range(99) < 80) ? $urandom_range(hi)
				: $urandom_range(TAB_DEPTH - 1));
		end else if (sel < 95) begin
			c = query_cmd(rand_coord(), rand_coord(), $urandom_range(99) < 90, 1'b0, '0, '0, 1'b0);
		end else begin
			c = load_cmd(OP_UNUSED, IDX_W'($urandom), $urandom, 1'($urandom_range(1)));
		end
		return c;
	endfunction

	function automatic void apply_transfer(input grid_cmd_t c);
		lookup_res_t r;
		case (c.op)
			OP_LOAD_LAT: begin
				lat_val[c.idx] = c.val;
				lat_ok[c.idx]  = c.ev;
				n_loads++;
			end
			OP_LOAD_LON: begin
				lon_val[c.idx] = c.val;
				lon_ok[c.idx]  = c.ev;
				n_loads++;
			end
			OP_QUERY: begin
				r = c.typed ? lookup_res_t'{row: c.er, col: c.ec, fnd: c.ef}
					: predict_lookup(c.qlat, c.qlon, c.qv);
				lookup_q.push_back(r);
				n_queries++;
				if (r.fnd)
					n_hits++;
			end
			default: ;
		endcase
	endfunction

	task automatic issue(input grid_cmd_t c);
		start       <= 1'b1;
		opcode      <= c.op;
		entry_index <= c.idx;
		entry_value <= c.val;
		entry_valid <= c.ev;
		query_lat   <= c.qlat;
		query_lon   <= c.qlon;
		query_valid <= c.qv;
		do @(posedge clk); while (busy !== 1'b0);
		apply_transfer(c);
	endtask

	task automatic set_register(input logic [2:0] addr, input logic [CNT_W-1:0] value);
		logic [31:0] garbage;
		garbage = $urandom_range(1) ? $urandom : 32'd0;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {garbage[31:CNT_W], value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_ROWS)
			rows_cfg = value;
		else
			cols_cfg = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== {{(32 - CNT_W){1'b0}}, value}) begin
			$error("prdata: expected %0d, got %0d", value, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		lookup_res_t e;
		if (arst_n && result_strobe === 1'b1) begin
			if (lookup_q.size() == 0) begin
				$error("result transfer with no query outstanding");
				errors++;
			end else begin
				e = lookup_q.pop_front();
				if (row_index !== e.row) begin
					$error("row_index: expected %0d, got %0d", e.row, row_index);
					errors++;
				end
				if (col_index !== e.col) begin
					$error("col_index: expected %0d, got %0d", e.col, col_index);
					errors++;
				end
				if (found !== e.fnd) begin
					$error("found: expected %0d, got %0d", e.fnd, found);
					errors++;
				end
			end
		end
	end

	initial begin
		grid_cmd_t directed[$];
		grid_cmd_t c;
		int        done_items;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			lat_val[i] = '0;
			lat_ok[i]  = 1'b0;
			lon_val[i] = '0;
			lon_ok[i]  = 1'b0;
		end

		directed.push_back(query_cmd(0, 0, 1'b1, 1'b1, 0, 0, 1'b0));
		directed.push_back(query_cmd(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b1, 0, 0, 1'b0));
		directed.push_back(load_cmd(OP_LOAD_LAT, 0, 32'sh7FFF_FFFF, 1'b1));
		directed.push_back(query_cmd(0, 0, 1'b1, 1'b1, 0, 0, 1'b0));
		directed.push_back(load_cmd(OP_LOAD_LON, 1023, 32'sh8000_0000, 1'b1));
		directed.push_back(query_cmd(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1, 0, 1023, 1'b1));
		directed.push_back(load_cmd(OP_LOAD_LAT, 5, 100, 1'b1));
		directed.push_back(load_cmd(OP_LOAD_LAT, 3, -100, 1'b1));
		directed.push_back(query_cmd(0, 0, 1'b1, 1'b1, 3, 1023, 1'b1));
		directed.push_back(load_cmd(OP_LOAD_LAT, 3, -100, 1'b0));
		directed.push_back(query_cmd(0, 0, 1'b1, 1'b1, 5, 1023, 1'b1));
		directed.push_back(load_cmd(OP_UNUSED, 10'h3FF, -32'sd1, 1'b1));
		directed.push_back(load_cmd(OP_LOAD_LON, 7, 32'sh8000_0000, 1'b1));
		directed.push_back(query_cmd(32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b1, 5, 7, 1'b1));
		directed.push_back(load_cmd(OP_LOAD_LAT, 1023, -32'sd1, 1'b1));
		directed.push_back(load_cmd(OP_LOAD_LON, 0, 32'sh5A5A_5A5A, 1'b1));
		directed.push_back(query_cmd(0, 0, 1'b0, 1'b1, 0, 0, 1'b0));
		directed.push_back(load_cmd(OP_LOAD_LAT, 10'h2AA, 32'sh2AAA_AAAA, 1'b1));
		directed.push_back(load_cmd(OP_LOAD_LON, 10'h155, 32'shD555_5555, 1'b1));
		directed.push_back(query_cmd(32'sh2AAA_AAA0, 32'shD555_5550, 1'b1, 1'b0, 0, 0, 1'b0));
		directed.push_back(query_cmd(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b0, 0, 0, 1'b0));
		directed.push_back(query_cmd(32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b0, 0, 0, 1'b0));
		directed.push_back(load_cmd(OP_LOAD_LAT, 0, 0, 1'b0));
		directed.push_back(query_cmd(32'sh7FFF_FFFF, 0, 1'b1, 1'b0, 0, 0, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i]);
		start <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			while (lookup_q.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
			set_register(ADDR_ROWS, CNT_W'(plan_rows[p]));
			set_register(ADDR_COLS, CNT_W'(plan_cols[p]));
			done_items = 0;
			while (done_items < plan_items[p]) begin
				if (p != CALM_PHASE && $urandom_range(99) < 4) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end
				c = random_cmd();
				issue(c);
				if (c.op != OP_UNUSED)
					done_items++;
			end
			start <= 1'b0;
		end

		while (lookup_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Ran %0d table loads and %0d queries (%0d with a nearest entry found)",
			n_loads, n_queries, n_hits);
		$display("over %0d scan length settings, including zero and above the table depth",
			NUM_PHASES + 1);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
